@@ src/scsb_pkg.sv @@
// ----------------------------------------------------------------------------
// scsb_pkg: shared types, codes and arithmetic helpers
// Item formats, the command queue entry, and the border reflection and
// rounding helpers used by the separable filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scsb_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_MAX_RADIUS = 15;

  // Widths sized for the largest supported frame (4096) and radius (63).
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned RAD_W  = 6;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned PIX_W  = 16;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

  typedef enum logic [1:0] {
    OP_VTAP  = 2'd0,
    OP_HTAP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_VRAD   = 2'd2,
    CFG_HRAD   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [7:0]              row;
    logic [7:0]              col;
    logic [4:0]              tap;
    logic signed [PIX_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] result_pixel;
    logic                    status;
  } out_item_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RAD_W-1:0]  vrad;
    logic [RAD_W-1:0]  hrad;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_VTAP,
    CMD_HTAP,
    CMD_WRITE,
    CMD_READ,
    CMD_OOR
  } cmd_e;

  typedef struct packed {
    cmd_e                    kind;
    logic [7:0]              row;
    logic [7:0]              col;
    logic [4:0]              tap;
    logic signed [PIX_W-1:0] value;
  } cmd_t;

  // Reflected position: m is the in-image index, s set while walking mirrored.
  typedef struct packed {
    logic [POS_W-1:0] m;
    logic             s;
  } pos_t;

  // Advance the unreflected coordinate by +1.
  function automatic pos_t step_up(pos_t p, logic [SIZE_W-1:0] n);
    pos_t r;
    r = p;
    if (!p.s) begin
      if (p.m == POS_W'(n - SIZE_W'(1))) r.s = 1'b1;
      else r.m = p.m + POS_W'(1);
    end else begin
      if (p.m == '0) r.s = 1'b0;
      else r.m = p.m - POS_W'(1);
    end
    return r;
  endfunction

  // Advance the unreflected coordinate by -1.
  function automatic pos_t step_down(pos_t p, logic [SIZE_W-1:0] n);
    pos_t r;
    r = p;
    if (!p.s) begin
      if (p.m == '0) r.s = 1'b1;
      else r.m = p.m - POS_W'(1);
    end else begin
      if (p.m == POS_W'(n - SIZE_W'(1))) r.s = 1'b0;
      else r.m = p.m + POS_W'(1);
    end
    return r;
  endfunction

  // Q15 round half up, then saturate to 16 bits.
  function automatic logic signed [PIX_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = (acc + RND_HALF) >>> 15;
    if (t > SAT_HI) t = SAT_HI;
    if (t < SAT_LO) t = SAT_LO;
    return PIX_W'(t);
  endfunction

endpackage

`default_nettype wire

@@ src/scsb_stream_if.sv @@
// ----------------------------------------------------------------------------
// scsb_stream_if: valid/ready stream channel
// Carries one request per handshake; payload type is a parameter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scsb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/scsb_ram.sv @@
// ----------------------------------------------------------------------------
// scsb_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scsb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/scsb_front.sv @@
// ----------------------------------------------------------------------------
// scsb_front: request intake and command queue
// Classifies each request, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scsb_front import scsb_pkg::*; #(
  parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  scsb_stream_if.sink in_i,
  output      cmd_t   head_o,
  output      logic   head_valid_o,
  input  wire logic   pop_i
);

  localparam int unsigned TAPS = 2 * MAX_RADIUS + 1;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, push, in_image, tap_ok;
  cmd_t       cmd;

  assign in_i.ready   = (cnt_q != 2'd2);
  assign accept       = in_i.valid && in_i.ready;
  assign head_o       = mem_q[rd_q];
  assign head_valid_o = (cnt_q != 2'd0);

  always_comb begin
    in_image  = (SIZE_W'(in_i.data.row) < cfg_i.height) &&
                (SIZE_W'(in_i.data.col) < cfg_i.width);
    tap_ok    = (8'(in_i.data.tap) < 8'(TAPS));
    cmd.row   = in_i.data.row;
    cmd.col   = in_i.data.col;
    cmd.tap   = in_i.data.tap;
    cmd.value = in_i.data.value;
    cmd.kind  = CMD_VTAP;
    push      = 1'b0;
    unique case (opcode_e'(in_i.data.opcode))
      OP_VTAP: begin
        cmd.kind = CMD_VTAP;
        push     = tap_ok;
      end
      OP_HTAP: begin
        cmd.kind = CMD_HTAP;
        push     = tap_ok;
      end
      OP_WRITE: begin
        cmd.kind = CMD_WRITE;
        push     = in_image;
      end
      OP_READ: begin
        cmd.kind = in_image ? CMD_READ : CMD_OOR;
        push     = 1'b1;
      end
      default: ;
    endcase
    push  = push && accept;
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd;
  end

endmodule

`default_nettype wire

@@ src/scsb_back.sv @@
// ----------------------------------------------------------------------------
// scsb_back: command execution
// Tap tables, frame store, and the shared multiply-accumulate sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scsb_back import scsb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire cmd_t     head_i,
  input  wire logic     head_valid_i,
  output      logic     pop_o,
  scsb_stream_if.source out_o
);

  localparam int unsigned TAPS  = 2 * MAX_RADIUS + 1;
  localparam int unsigned TI_W  = $clog2(TAPS + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_VRUN, ST_VDRAIN, ST_HMID, ST_HMUL, ST_HACC, ST_FIN
  } state_e;

  state_e                   state_q;
  logic signed [PIX_W-1:0]  vtap_q [TAPS];
  logic signed [PIX_W-1:0]  htap_q [TAPS];
  pos_t                     vpos_q, vpos0_q, hpos_q;
  logic [TI_W-1:0]          vcnt_q, hcnt_q;
  logic [RAD_W-1:0]         pre_q;
  logic                     v1_q, v2_q;
  logic signed [PIX_W-1:0]  coef1_q, mid_q;
  logic signed [2*PIX_W-1:0] prod_q, hprod_q;
  logic signed [ACC_W-1:0]  acc_v_q, acc_h_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic             out_free, out_set, ram_we, ram_re;
  logic [AW-1:0]    waddr, raddr;
  logic [PIX_W-1:0] rdata;

  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign pop_o  = (state_q == ST_IDLE) && head_valid_i &&
                  ((head_i.kind != CMD_OOR) || out_free);
  // a new result is loaded this cycle
  assign out_set = (pop_o && (head_i.kind == CMD_OOR)) ||
                   ((state_q == ST_FIN) && out_free);
  assign ram_we = pop_o && (head_i.kind == CMD_WRITE);
  assign ram_re = (state_q == ST_VRUN);
  assign waddr  = AW'(head_i.row) * ROW_STRIDE + AW'(head_i.col);
  assign raddr  = AW'(vpos_q.m) * ROW_STRIDE + AW'(hpos_q.m);

  scsb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (head_i.value),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < TAPS; i++) begin
        vtap_q[i] <= '0;
        htap_q[i] <= '0;
      end
      vpos_q      <= '0;
      vpos0_q     <= '0;
      hpos_q      <= '0;
      vcnt_q      <= '0;
      hcnt_q      <= '0;
      pre_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      coef1_q     <= '0;
      mid_q       <= '0;
      prod_q      <= '0;
      hprod_q     <= '0;
      acc_v_q     <= '0;
      acc_h_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_set) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      // vertical MAC pipe: issue, RAM read, multiply, accumulate
      v1_q    <= ram_re;
      coef1_q <= vtap_q[vcnt_q];
      v2_q    <= v1_q;
      prod_q  <= $signed(rdata) * coef1_q;
      if (v2_q) acc_v_q <= acc_v_q + ACC_W'(prod_q);

      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            case (head_i.kind)
              CMD_VTAP: vtap_q[TI_W'(head_i.tap)] <= head_i.value;
              CMD_HTAP: htap_q[TI_W'(head_i.tap)] <= head_i.value;
              CMD_READ: begin
                vpos_q  <= '{m: POS_W'(head_i.row), s: 1'b0};
                hpos_q  <= '{m: POS_W'(head_i.col), s: 1'b0};
                pre_q   <= '0;
                vcnt_q  <= '0;
                hcnt_q  <= '0;
                acc_v_q <= '0;
                acc_h_q <= '0;
                state_q <= ST_PRE;
              end
              CMD_OOR: begin
                out_q <= '{result_pixel: '0, status: 1'b1};
              end
              default: ;
            endcase
          end
        end
        ST_PRE: begin
          // walk to the first tap position (offset +radius)
          if (pre_q < cfg_i.vrad) vpos_q <= step_up(vpos_q, cfg_i.height);
          if (pre_q < cfg_i.hrad) hpos_q <= step_up(hpos_q, cfg_i.width);
          pre_q <= pre_q + RAD_W'(1);
          if (pre_q >= cfg_i.vrad && pre_q >= cfg_i.hrad) begin
            vpos0_q <= vpos_q;
            state_q <= ST_VRUN;
          end
        end
        ST_VRUN: begin
          vpos_q <= step_down(vpos_q, cfg_i.height);
          vcnt_q <= vcnt_q + TI_W'(1);
          if (vcnt_q == TI_W'({cfg_i.vrad, 1'b0})) state_q <= ST_VDRAIN;
        end
        ST_VDRAIN: begin
          if (!v1_q && !v2_q) state_q <= ST_HMID;
        end
        ST_HMID: begin
          mid_q   <= round_sat(acc_v_q);
          state_q <= ST_HMUL;
        end
        ST_HMUL: begin
          hprod_q <= mid_q * htap_q[hcnt_q];
          state_q <= ST_HACC;
        end
        ST_HACC: begin
          acc_h_q <= acc_h_q + ACC_W'(hprod_q);
          acc_v_q <= '0;
          vcnt_q  <= '0;
          vpos_q  <= vpos0_q;
          hpos_q  <= step_down(hpos_q, cfg_i.width);
          hcnt_q  <= hcnt_q + TI_W'(1);
          if (hcnt_q == TI_W'({cfg_i.hrad, 1'b0})) state_q <= ST_FIN;
          else state_q <= ST_VRUN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_q   <= '{result_pixel: round_sat(acc_h_q), status: 1'b0};
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/separable_convolution_symmetric_border.sv @@
// Tap loads and pixel writes retire one per cycle from the queue while no
// filtered read is in progress. A filtered read runs the vertical pass for each
// horizontal tap through the multiply-accumulate pipe and the registered frame
// store read; reads are processed one at a time.
// Out-of-image reads are answered from the idle state. Reset clears config to
// 256x256 with radius 0 and zeroes both tap tables; frame store is not cleared.
// ----------------------------------------------------------------------------
// separable_convolution_symmetric_border: separable 2-D FIR over one frame
// Front end queues requests; back end runs the vertical then horizontal
// pass with half-sample symmetric border reflection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module separable_convolution_symmetric_border import scsb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  scsb_stream_if.sink     in_i,
  scsb_stream_if.source   out_o
);

  // Raw register values as written by the host
  logic [8:0] width_q, height_q;
  logic [3:0] vrad_q, hrad_q;
  cfg_t       cfg;

  // Queue head between front and back
  cmd_t q_head;
  logic q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      vrad_q   <= '0;
      hrad_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_VRAD:   vrad_q   <= cfg_data_i[3:0];
        CFG_HRAD:   hrad_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective config: zero size acts as 1, anything past the max is clamped
  always_comb begin
    if (width_q == '0) cfg.width = SIZE_W'(1);
    else if (SIZE_W'(width_q) > SIZE_W'(MAX_WIDTH)) cfg.width = SIZE_W'(MAX_WIDTH);
    else cfg.width = SIZE_W'(width_q);
    if (height_q == '0) cfg.height = SIZE_W'(1);
    else if (SIZE_W'(height_q) > SIZE_W'(MAX_HEIGHT)) cfg.height = SIZE_W'(MAX_HEIGHT);
    else cfg.height = SIZE_W'(height_q);
    cfg.vrad = (RAD_W'(vrad_q) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(vrad_q);
    cfg.hrad = (RAD_W'(hrad_q) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(hrad_q);
  end

  scsb_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .head_o       (q_head),
    .head_valid_o (q_valid),
    .pop_i        (q_pop)
  );

  scsb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  // back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // a full queue is never seen as empty
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_valid) else $error("stalled input with empty queue");

  // out-of-image reads carry a zero pixel
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status) |-> (out_o.data.result_pixel == '0))
    else $error("nonzero pixel on error status");
`endif

endmodule

`default_nettype wire

@@ dv/separable_convolution_symmetric_border_tb.sv @@
// ----------------------------------------------------------------------------
// separable_convolution_symmetric_border_tb: self-checking bench for the filter
// A directed table, then random phases across frame sizes and radii. Each read
// result is checked against an in-bench Q1.15 separable filter with half-sample
// symmetric borders, or against the result given in its directed table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module separable_convolution_symmetric_border_tb;
  import scsb_pkg::*;

  localparam int FRAME_W    = 256;
  localparam int FRAME_H    = 256;
  localparam int TAPS       = 31;
  localparam int IDLE_LIMIT = 20000;  // longest quiet stretch: hold-off plus one slow read
  localparam int HOLD_LEN   = 3000;
  localparam int SETTLE     = 200;    // queued loads/writes retiring after the last result

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_WIDTH;
  logic [8:0] cfg_data = '0;

  scsb_stream_if #(.T(in_item_t))  req_if ();
  scsb_stream_if #(.T(out_item_t)) rsp_if ();

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  separable_convolution_symmetric_border DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (req_if),
    .out_o     (rsp_if)
  );

  // ---------------------------------------------------------------- mirror state
  logic signed [15:0] pix_mirror [FRAME_W*FRAME_H];
  logic signed [15:0] vtap_mirror [TAPS];
  logic signed [15:0] htap_mirror [TAPS];
  logic [8:0] width_reg, height_reg;
  logic [3:0] vrad_reg, hrad_reg;

  out_item_t pending_q [$];
  int errors, reads_checked, oor_checked, cfg_writes;
  int snd_idle_pct, rcv_stall_pct;
  int hold_req, hold_seen, hold_cnt;

  function automatic int eff_size(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // half-sample symmetric fold with a non-negative modulo of 2n
  function automatic int fold(int t, int n);
    int p, m;
    p = 2 * n;
    m = t % p;
    if (m < 0) m += p;
    if (m > n - 1) m = p - 1 - m;
    return m;
  endfunction

  function automatic logic signed [15:0] q15_round(longint acc);
    longint q;
    q = (acc + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic out_item_t filter_at(int row, int col);
    out_item_t r;
    int w, h, rv, rh, c;
    longint acc, vacc;
    w  = eff_size(width_reg, FRAME_W);
    h  = eff_size(height_reg, FRAME_H);
    rv = vrad_reg;
    rh = hrad_reg;
    r  = '0;
    if (row >= h || col >= w) begin
      r.status = 1'b1;
      return r;
    end
    acc = 0;
    for (int k = -rh; k <= rh; k++) begin
      c = fold(col - k, w);
      vacc = 0;
      for (int j = -rv; j <= rv; j++)
        vacc += longint'(vtap_mirror[rv+j]) * longint'(pix_mirror[fold(row - j, h) * FRAME_W + c]);
      acc += longint'(htap_mirror[rh+k]) * longint'(q15_round(vacc));
    end
    r.result_pixel = q15_round(acc);
    return r;
  endfunction

  // Applies one accepted request to the mirror; reads queue their expectation.
  function automatic void apply_request(in_item_t it);
    int w, h;
    w = eff_size(width_reg, FRAME_W);
    h = eff_size(height_reg, FRAME_H);
    case (opcode_e'(it.opcode))
      OP_VTAP:  if (it.tap < TAPS) vtap_mirror[it.tap] = it.value;
      OP_HTAP:  if (it.tap < TAPS) htap_mirror[it.tap] = it.value;
      OP_WRITE: if (it.row < h && it.col < w) pix_mirror[it.row * FRAME_W + it.col] = it.value;
      default:  pending_q.push_back(filter_at(it.row, it.col));
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_request(in_item_t it, bit typed, out_item_t typed_rsp);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    if (typed) pending_q.push_back(typed_rsp);
    else apply_request(it);
  endtask

  // Sender pauses until every result is back, then lets queued writes retire.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [8:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_WIDTH:  width_reg  = val;
      CFG_HEIGHT: height_reg = val;
      CFG_VRAD:   vrad_reg   = val[3:0];
      default:    hrad_reg   = val[3:0];
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(16383)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t mk(opcode_e op, int row, int col, int tap, int val);
    in_item_t it;
    it.opcode = op;
    it.row    = row[7:0];
    it.col    = col[7:0];
    it.tap    = tap[4:0];
    it.value  = val[15:0];
    return it;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_LEN;
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: result_pixel %0d status %0d",
               rsp_if.data.result_pixel, rsp_if.data.status);
        errors++;
      end else begin
        out_item_t want;
        want = pending_q.pop_front();
        if (rsp_if.data.result_pixel !== want.result_pixel) begin
          $error("result_pixel: expected %0d, actual %0d", want.result_pixel,
                 rsp_if.data.result_pixel);
          errors++;
        end
        if (rsp_if.data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.data.status);
          errors++;
        end
        if (want.status) oor_checked++;
        else reads_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet_cycles;
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("separable_convolution_symmetric_border verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- directed table
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e kind;
    in_item_t  it;
    cfg_idx_e  idx;
    int        cfg_val;
    bit        typed;
    out_item_t rsp;
  } dir_row_t;

  dir_row_t dir_tbl [$];

  function automatic void add_req(in_item_t it, bit typed = 0, int pixel = 0, int st = 0);
    dir_row_t r;
    r.kind = ROW_REQ;
    r.it = it;
    r.idx = CFG_WIDTH;
    r.cfg_val = 0;
    r.typed = typed;
    r.rsp.result_pixel = pixel[15:0];
    r.rsp.status = st[0];
    dir_tbl.push_back(r);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, int val);
    dir_row_t r;
    r = '{ROW_CFG, '0, idx, val, 1'b0, '0};
    dir_tbl.push_back(r);
  endfunction

  function automatic void build_directed();
    // taps are all zero after reset, so these reads must come back zero
    add_req(mk(OP_WRITE, 0, 0, 0, 32767));
    add_req(mk(OP_READ, 0, 0, 0, 0), 1, 0, 0);
    add_req(mk(OP_WRITE, 255, 255, 0, -32768));
    add_req(mk(OP_READ, 255, 255, 0, 0), 1, 0, 0);
    add_req(mk(OP_VTAP, 0, 0, 0, 32767));
    add_req(mk(OP_HTAP, 0, 0, 0, -32768));
    add_req(mk(OP_VTAP, 0, 0, 31, 1234));     // tap index too large: dropped
    add_req(mk(OP_HTAP, 0, 0, 31, -1234));
    add_req(mk(OP_READ, 0, 0, 0, 0));
    add_req(mk(OP_READ, 255, 255, 0, 0));
    // zero width acts as one; radius far beyond a two-row image
    add_cfg(CFG_WIDTH, 0);
    add_cfg(CFG_HEIGHT, 2);
    add_cfg(CFG_VRAD, 15);
    add_cfg(CFG_HRAD, 15);
    add_req(mk(OP_WRITE, 1, 0, 0, -1234));
    add_req(mk(OP_VTAP, 0, 0, 30, 16384));
    add_req(mk(OP_HTAP, 0, 0, 30, 32767));
    add_req(mk(OP_WRITE, 5, 5, 0, 77));       // outside the image: dropped
    add_req(mk(OP_READ, 0, 0, 0, 0));
    add_req(mk(OP_READ, 1, 0, 0, 0));
    add_req(mk(OP_READ, 0, 1, 0, 0), 1, 0, 1);
    add_req(mk(OP_READ, 2, 0, 0, 0), 1, 0, 1);
  endfunction

  // ---------------------------------------------------------------- random phases
  task automatic run_phase(int p);
    int wv, hv, rv, rh, w, h, n_items;
    in_item_t it;
    n_items = 20;
    case (p)
      0:       begin wv = 511; hv = 1;   rv = 0;  rh = 15; end
      1:       begin wv = 1;   hv = 24;  rv = 15; rh = 0;  end
      2:       begin wv = 0;   hv = 0;   rv = 2;  rh = 2;  end
      3:       begin wv = 3;   hv = 2;   rv = 15; rh = 15; end
      default: begin
        wv = $urandom_range(1, 8);
        hv = $urandom_range(1, 8);
        rv = $urandom_range(0, 4);
        rh = $urandom_range(0, 4);
      end
    endcase
    case (p % 4)
      0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1:       begin snd_idle_pct = 88; rcv_stall_pct = 0;  end
      2:       begin snd_idle_pct = 0;  rcv_stall_pct = 88; end
      default: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
    endcase
    write_reg(CFG_WIDTH, wv[8:0]);
    write_reg(CFG_HEIGHT, hv[8:0]);
    write_reg(CFG_VRAD, rv[8:0]);
    write_reg(CFG_HRAD, rh[8:0]);
    w = eff_size(width_reg, FRAME_W);
    h = eff_size(height_reg, FRAME_H);
    // fill the whole image first so no read can reach an unwritten pixel
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        send_request(mk(OP_WRITE, r, c, 0, pick_value()), 0, '0);
    for (int t = 0; t <= rv; t++)
      send_request(mk(OP_VTAP, 0, 0, $urandom_range(TAPS - 1), pick_value()), 0, '0);
    for (int t = 0; t <= rh; t++)
      send_request(mk(OP_HTAP, 0, 0, $urandom_range(TAPS - 1), pick_value()), 0, '0);
    // receiver stops for a long stretch while requests keep coming
    if (p == 2) hold_req++;
    for (int i = 0; i < n_items; i++) begin
      it = in_item_t'({$urandom, $urandom});
      if ($urandom_range(9) < 8) begin
        it.row = $urandom_range(h - 1);
        it.col = $urandom_range(w - 1);
        it.value = pick_value();
        case ($urandom_range(9))
          0, 1, 2, 3, 4: it.opcode = OP_READ;
          5, 6:          it.opcode = OP_WRITE;
          default:       it.opcode = $urandom_range(1) ? OP_VTAP : OP_HTAP;
        endcase
      end
      send_request(it, 0, '0);
    end
    drain();
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    for (int i = 0; i < TAPS; i++) begin
      vtap_mirror[i] = '0;
      htap_mirror[i] = '0;
    end
    width_reg = 9'd256;
    height_reg = 9'd256;
    vrad_reg = '0;
    hrad_reg = '0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    build_directed();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_tbl[i].idx, dir_tbl[i].cfg_val[8:0]);
      end else begin
        send_request(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].rsp);
      end
    end
    drain();

    for (int p = 0; p < 8; p++) run_phase(p);

    $display("covered %0d filtered reads and %0d out-of-image reads over %0d register writes",
             reads_checked, oor_checked, cfg_writes);
    $display("sizes from 1x1 up to a clamped full-width row, radii 0 to 15");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("separable_convolution_symmetric_border verification clean");
    end else begin
      $display("separable_convolution_symmetric_border verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/scsb_pkg.sv
src/scsb_stream_if.sv
src/scsb_ram.sv
src/scsb_front.sv
src/scsb_back.sv
src/separable_convolution_symmetric_border.sv
dv/separable_convolution_symmetric_border_tb.sv
